@@ rtl/core/vcwl_pkg.sv @@
// Package for the velocity command watchdog limiter.
// Holds the configuration and result types, action and register codes and reset values.
// No dependencies; used by the register file and the top level.
package vcwl_pkg;

  // Input item action codes.
  localparam logic [1:0] ACT_COMMAND = 2'd0;
  localparam logic [1:0] ACT_TICK    = 2'd1;
  localparam logic [1:0] ACT_START   = 2'd2;
  localparam logic [1:0] ACT_STOP    = 2'd3;

  // Request kinds on the output channel.
  localparam logic KIND_VELOCITY = 1'b0;
  localparam logic KIND_START    = 1'b1;

  // Register indexes (byte address is four times the index).
  localparam logic [2:0] REG_TIMEOUT   = 3'd0;
  localparam logic [2:0] REG_HOLD      = 3'd1;
  localparam logic [2:0] REG_LIMIT_X   = 3'd2;
  localparam logic [2:0] REG_LIMIT_Y   = 3'd3;
  localparam logic [2:0] REG_LIMIT_T   = 3'd4;
  localparam logic [2:0] REG_DB_LIN    = 3'd5;
  localparam logic [2:0] REG_DB_TURN   = 3'd6;
  localparam logic [2:0] REG_MODE      = 3'd7;

  localparam int unsigned ADDR_W = 5;

  // Reset values of the configuration registers.
  localparam logic [15:0] RST_TIMEOUT  = 16'd500;
  localparam logic [15:0] RST_HOLD     = 16'd600;
  localparam logic [14:0] RST_LIMIT_X  = 15'd2048;
  localparam logic [14:0] RST_LIMIT_Y  = 15'd1229;
  localparam logic [14:0] RST_LIMIT_T  = 15'd3277;
  localparam logic [14:0] RST_DB_LIN   = 15'd4;
  localparam logic [14:0] RST_DB_TURN  = 15'd4;
  localparam logic [1:0]  RST_MODE     = 2'd2;

  // Mode bit positions.
  localparam int unsigned MODE_AUTO_START = 0;
  localparam int unsigned MODE_EARLY_STOP = 1;

  typedef struct packed {
    logic [15:0] timeout_ms;
    logic [15:0] hold_duration_ms;
    logic [14:0] limit_x;
    logic [14:0] limit_y;
    logic [14:0] limit_turn;
    logic [14:0] deadband_lin;
    logic [14:0] deadband_turn;
    logic [1:0]  mode_bits;
  } cfg_t;

  typedef struct packed {
    logic               request_kind;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_turn;
    logic [15:0]        out_duration_ms;
    logic               last_of_run;
  } result_t;

endpackage

@@ rtl/core/vcwl_if.sv @@
// Channel interfaces for the velocity command watchdog limiter.
// vcwl_cmd_if carries input items, vcwl_req_if carries result items.
// No dependencies.
interface vcwl_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [31:0]        stamp_ms;
  logic signed [15:0] cmd_x;
  logic signed [15:0] cmd_y;
  logic signed [15:0] cmd_turn;

  modport source (output valid, action, stamp_ms, cmd_x, cmd_y, cmd_turn, input ready);
  modport sink   (input valid, action, stamp_ms, cmd_x, cmd_y, cmd_turn, output ready);
endinterface

interface vcwl_req_if;
  logic               valid;
  logic               ready;
  logic               request_kind;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic signed [15:0] out_turn;
  logic [15:0]        out_duration_ms;
  logic               last_of_run;

  modport source (output valid, request_kind, out_x, out_y, out_turn, out_duration_ms,
                  last_of_run, input ready);
  modport sink   (input valid, request_kind, out_x, out_y, out_turn, out_duration_ms,
                  last_of_run, output ready);
endinterface

@@ rtl/core/vcwl_regs.sv @@
// APB-style configuration register file for the watchdog limiter.
// Depends on vcwl_pkg for the register indexes, reset values and cfg_t.
module vcwl_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vcwl_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output vcwl_pkg::cfg_t              cfg
);

  logic          wr_en;
  logic [2:0]    index;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign index  = paddr[vcwl_pkg::ADDR_W-1:2];

  // Register writes on the access cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ms       <= vcwl_pkg::RST_TIMEOUT;
      cfg.hold_duration_ms <= vcwl_pkg::RST_HOLD;
      cfg.limit_x          <= vcwl_pkg::RST_LIMIT_X;
      cfg.limit_y          <= vcwl_pkg::RST_LIMIT_Y;
      cfg.limit_turn       <= vcwl_pkg::RST_LIMIT_T;
      cfg.deadband_lin     <= vcwl_pkg::RST_DB_LIN;
      cfg.deadband_turn    <= vcwl_pkg::RST_DB_TURN;
      cfg.mode_bits        <= vcwl_pkg::RST_MODE;
    end else if (wr_en) begin
      unique case (index)
        vcwl_pkg::REG_TIMEOUT: cfg.timeout_ms       <= pwdata[15:0];
        vcwl_pkg::REG_HOLD:    cfg.hold_duration_ms <= pwdata[15:0];
        vcwl_pkg::REG_LIMIT_X: cfg.limit_x          <= pwdata[14:0];
        vcwl_pkg::REG_LIMIT_Y: cfg.limit_y          <= pwdata[14:0];
        vcwl_pkg::REG_LIMIT_T: cfg.limit_turn       <= pwdata[14:0];
        vcwl_pkg::REG_DB_LIN:  cfg.deadband_lin     <= pwdata[14:0];
        vcwl_pkg::REG_DB_TURN: cfg.deadband_turn    <= pwdata[14:0];
        vcwl_pkg::REG_MODE:    cfg.mode_bits        <= pwdata[1:0];
      endcase
    end
  end

  // Read mux, zero extended to the bus width.
  always_comb begin
    unique case (index)
      vcwl_pkg::REG_TIMEOUT: prdata = {16'd0, cfg.timeout_ms};
      vcwl_pkg::REG_HOLD:    prdata = {16'd0, cfg.hold_duration_ms};
      vcwl_pkg::REG_LIMIT_X: prdata = {17'd0, cfg.limit_x};
      vcwl_pkg::REG_LIMIT_Y: prdata = {17'd0, cfg.limit_y};
      vcwl_pkg::REG_LIMIT_T: prdata = {17'd0, cfg.limit_turn};
      vcwl_pkg::REG_DB_LIN:  prdata = {17'd0, cfg.deadband_lin};
      vcwl_pkg::REG_DB_TURN: prdata = {17'd0, cfg.deadband_turn};
      vcwl_pkg::REG_MODE:    prdata = {30'd0, cfg.mode_bits};
    endcase
  end

endmodule

@@ rtl/core/velocity_command_watchdog_limiter.sv @@
// Top level of the velocity command watchdog limiter.
// Depends on vcwl_pkg, the channel interfaces in vcwl_if.sv and vcwl_regs.
//
//   channel | kind      | carries
//   --------+-----------+-------------------------------------------------
//   cmd     | sink      | commands, publish ticks, manual start and stop
//   req     | source    | velocity and start requests, last_of_run marked
//   apb     | APB slave | eight configuration registers at 4*index
//
// An accepted item is loaded into an input register, is processed from there
// and its results enter a three-entry result queue whose entry 0 drives req.
// One item can enter every cycle as long as the queue has room for two
// results; a tick that causes two results can therefore hold the input side
// until req takes a result.
// Reset is synchronous and clears the flags, the input valid bit and the queue count.
module velocity_command_watchdog_limiter (
  input  logic                        clk,
  input  logic                        rst,
  vcwl_cmd_if.sink                    cmd,
  vcwl_req_if.source                  req,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vcwl_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  // Deadband then clamp of one axis.
  function automatic logic signed [15:0] shape_axis(input logic signed [15:0] v,
                                                    input logic [14:0] db,
                                                    input logic [14:0] lim);
    logic signed [16:0] v_ext;
    logic signed [16:0] lim_ext;
    logic signed [16:0] neg_lim;
    logic [16:0]        mag;
    logic signed [15:0] r;
    v_ext   = {v[15], v};
    lim_ext = {2'b00, lim};
    neg_lim = -lim_ext;
    mag     = v[15] ? 17'(-v_ext) : 17'(v_ext);
    if (mag < {2'b00, db}) begin
      r = 16'sd0;
    end else if (v_ext > lim_ext) begin
      r = {1'b0, lim};
    end else if (v_ext < neg_lim) begin
      r = neg_lim[15:0];
    end else begin
      r = v;
    end
    return r;
  endfunction

  vcwl_pkg::cfg_t cfg;

  vcwl_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register.
  logic               in_valid;
  logic [1:0]         in_action;
  logic [31:0]        in_stamp;
  logic signed [15:0] in_x;
  logic signed [15:0] in_y;
  logic signed [15:0] in_turn;

  // Held command state.
  logic               have_command;
  logic               stop_done;
  logic               started;
  logic signed [15:0] held_x;
  logic signed [15:0] held_y;
  logic signed [15:0] held_turn;
  logic [31:0]        held_stamp;

  logic               have_command_next;
  logic               stop_done_next;
  logic               started_next;

  // Result queue, entry 0 drives req.
  vcwl_pkg::result_t  slot [3];
  vcwl_pkg::result_t  slot_next [3];
  logic [1:0]         cnt;
  logic [1:0]         cnt_next;
  logic [1:0]         base;
  logic               pop;
  logic               fire;

  vcwl_pkg::result_t  res0;
  vcwl_pkg::result_t  res1;
  vcwl_pkg::result_t  stop_res;
  vcwl_pkg::result_t  start_res;
  vcwl_pkg::result_t  vel_res;
  logic [1:0]         n_res;
  logic [31:0]        age;
  logic               live;
  logic               moving;

  // Queue occupancy after this cycle's pop decides whether the item runs.
  assign pop       = req.valid & req.ready;
  assign base      = cnt - {1'b0, pop};
  assign fire      = in_valid && (base <= 2'd1);
  assign cmd.ready = !in_valid || fire;

  assign req.valid           = (cnt != 2'd0);
  assign req.request_kind    = slot[0].request_kind;
  assign req.out_x           = slot[0].out_x;
  assign req.out_y           = slot[0].out_y;
  assign req.out_turn        = slot[0].out_turn;
  assign req.out_duration_ms = slot[0].out_duration_ms;
  assign req.last_of_run     = slot[0].last_of_run;

  // Input register load.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
    if (cmd.ready && cmd.valid) begin
      in_action <= cmd.action;
      in_stamp  <= cmd.stamp_ms;
      in_x      <= cmd.cmd_x;
      in_y      <= cmd.cmd_y;
      in_turn   <= cmd.cmd_turn;
    end
  end

  // Decide the results of the item in the input register.
  always_comb begin
    stop_res.request_kind    = vcwl_pkg::KIND_VELOCITY;
    stop_res.out_x           = 16'sd0;
    stop_res.out_y           = 16'sd0;
    stop_res.out_turn        = 16'sd0;
    stop_res.out_duration_ms = cfg.hold_duration_ms;
    stop_res.last_of_run     = 1'b0;

    start_res                 = stop_res;
    start_res.request_kind    = vcwl_pkg::KIND_START;
    start_res.out_duration_ms = 16'd0;

    vel_res          = stop_res;
    vel_res.out_x    = held_x;
    vel_res.out_y    = held_y;
    vel_res.out_turn = held_turn;

    age    = in_stamp - held_stamp;
    live   = (age <= {16'd0, cfg.timeout_ms});
    moving = (held_x != 16'sd0) || (held_y != 16'sd0) || (held_turn != 16'sd0);

    res0              = stop_res;
    res1              = vel_res;
    n_res             = 2'd0;
    have_command_next = have_command;
    stop_done_next    = stop_done;
    started_next      = started;

    unique case (in_action)
      vcwl_pkg::ACT_COMMAND: begin
        have_command_next = 1'b1;
        stop_done_next    = 1'b0;
      end
      vcwl_pkg::ACT_TICK: begin
        if (!have_command) begin
          if (cfg.mode_bits[vcwl_pkg::MODE_EARLY_STOP] && !stop_done) begin
            n_res          = 2'd1;
            stop_done_next = 1'b1;
          end
        end else if (live) begin
          stop_done_next = 1'b0;
          if (cfg.mode_bits[vcwl_pkg::MODE_AUTO_START] && !started && moving) begin
            res0         = start_res;
            n_res        = 2'd2;
            started_next = 1'b1;
          end else begin
            res0  = vel_res;
            n_res = 2'd1;
          end
        end else if (!stop_done) begin
          n_res          = 2'd1;
          stop_done_next = 1'b1;
        end
      end
      vcwl_pkg::ACT_START: begin
        res0         = start_res;
        n_res        = 2'd1;
        started_next = 1'b1;
      end
      vcwl_pkg::ACT_STOP: begin
        n_res          = 2'd1;
        stop_done_next = 1'b1;
      end
    endcase

    res0.last_of_run = (n_res == 2'd1);
    res1.last_of_run = 1'b1;
  end

  // Queue update: shift out on pop, then append this item's results.
  always_comb begin
    slot_next = slot;
    if (pop) begin
      slot_next[0] = slot[1];
      slot_next[1] = slot[2];
    end
    if (fire) begin
      for (int j = 0; j < 3; j++) begin
        if ((2'(j) == base) && (n_res != 2'd0)) begin
          slot_next[j] = res0;
        end else if ((n_res == 2'd2) && (2'(j) == base + 2'd1)) begin
          slot_next[j] = res1;
        end
      end
    end
    cnt_next = base + (fire ? n_res : 2'd0);
  end

  // Queue and state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= 2'd0;
      have_command <= 1'b0;
      stop_done    <= 1'b0;
      started      <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (fire) begin
        have_command <= have_command_next;
        stop_done    <= stop_done_next;
        started      <= started_next;
      end
    end
    slot <= slot_next;
    if (fire && (in_action == vcwl_pkg::ACT_COMMAND)) begin
      held_x     <= shape_axis(in_x, cfg.deadband_lin, cfg.limit_x);
      held_y     <= shape_axis(in_y, cfg.deadband_lin, cfg.limit_y);
      held_turn  <= shape_axis(in_turn, cfg.deadband_turn, cfg.limit_turn);
      held_stamp <= in_stamp;
    end
  end

endmodule

@@ tb/sv/tb_velocity_command_watchdog_limiter.sv @@
// Testbench for the velocity command watchdog limiter: directed and random items on the
// command channel, random stalls on both channels, and APB register writes between phases.
// Depends on vcwl_pkg, the channel interfaces in vcwl_if.sv and the top level of the block.
module tb_velocity_command_watchdog_limiter;

  typedef struct {
    logic [1:0]         action;
    logic [31:0]        stamp;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] turn;
  } action_item_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [vcwl_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  vcwl_cmd_if cmd_ch();
  vcwl_req_if req_ch();

  velocity_command_watchdog_limiter dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .req     (req_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk = ~clk;

  // Items waiting to be sent, and requests the block still owes us.
  action_item_t      queued_actions[$];
  vcwl_pkg::result_t due_requests[$];
  action_item_t      on_wire;
  bit                sending = 1'b0;
  int                send_idle_pct;
  int                recv_idle_pct;
  int                mismatches = 0;
  int                checked = 0;
  logic [31:0]       cmd_stamp = '0;

  // Predicted register contents and watchdog state.
  vcwl_pkg::cfg_t     cfg_now;
  logic               cmd_seen;
  logic               stop_sent;
  logic               start_sent;
  logic signed [15:0] kept_x;
  logic signed [15:0] kept_y;
  logic signed [15:0] kept_turn;
  logic [31:0]        kept_stamp;

  // Deadband first, then symmetric clamp to the axis limit.
  function automatic logic signed [15:0] shape_speed(logic signed [15:0] v, logic [14:0] db,
                                                     logic [14:0] lim);
    int s, mag, dbi, limi;
    logic signed [15:0] res;
    s = v;
    dbi = db;
    limi = lim;
    mag = (s < 0) ? -s : s;
    res = v;
    if (mag < dbi) begin
      res = '0;
    end else if (s > limi) begin
      res = 16'(limi);
    end else if (s < -limi) begin
      res = 16'(-limi);
    end
    return res;
  endfunction

  function automatic vcwl_pkg::result_t make_request(logic kind, logic signed [15:0] x,
                                                     logic signed [15:0] y,
                                                     logic signed [15:0] t,
                                                     logic [15:0] dur);
    vcwl_pkg::result_t r;
    r.request_kind = kind;
    r.out_x = x;
    r.out_y = y;
    r.out_turn = t;
    r.out_duration_ms = dur;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  // Works out the requests one accepted item causes and queues them in order.
  function automatic void watchdog_step(action_item_t it);
    vcwl_pkg::result_t run[$];
    logic [31:0]       age;
    logic              moving;
    case (it.action)
      vcwl_pkg::ACT_COMMAND: begin
        kept_x = shape_speed(it.x, cfg_now.deadband_lin, cfg_now.limit_x);
        kept_y = shape_speed(it.y, cfg_now.deadband_lin, cfg_now.limit_y);
        kept_turn = shape_speed(it.turn, cfg_now.deadband_turn, cfg_now.limit_turn);
        kept_stamp = it.stamp;
        cmd_seen = 1'b1;
        stop_sent = 1'b0;
      end
      vcwl_pkg::ACT_TICK: begin
        if (!cmd_seen) begin
          if (cfg_now.mode_bits[vcwl_pkg::MODE_EARLY_STOP] && !stop_sent) begin
            run = {run, make_request(vcwl_pkg::KIND_VELOCITY, 0, 0, 0,
                                     cfg_now.hold_duration_ms)};
            stop_sent = 1'b1;
          end
        end else begin
          age = it.stamp - kept_stamp;
          if (age <= cfg_now.timeout_ms) begin
            moving = (kept_x != 0) || (kept_y != 0) || (kept_turn != 0);
            if (cfg_now.mode_bits[vcwl_pkg::MODE_AUTO_START] && !start_sent && moving) begin
              run = {run, make_request(vcwl_pkg::KIND_START, 0, 0, 0, 0)};
              start_sent = 1'b1;
            end
            run = {run, make_request(vcwl_pkg::KIND_VELOCITY, kept_x, kept_y, kept_turn,
                                     cfg_now.hold_duration_ms)};
            stop_sent = 1'b0;
          end else if (!stop_sent) begin
            run = {run, make_request(vcwl_pkg::KIND_VELOCITY, 0, 0, 0,
                                     cfg_now.hold_duration_ms)};
            stop_sent = 1'b1;
          end
        end
      end
      vcwl_pkg::ACT_START: begin
        run = {run, make_request(vcwl_pkg::KIND_START, 0, 0, 0, 0)};
        start_sent = 1'b1;
      end
      default: begin
        run = {run, make_request(vcwl_pkg::KIND_VELOCITY, 0, 0, 0,
                                 cfg_now.hold_duration_ms)};
        stop_sent = 1'b1;
      end
    endcase
    if (run.size() > 0) begin
      run[run.size() - 1].last_of_run = 1'b1;
    end
    foreach (run[i]) begin
      due_requests = {due_requests, run[i]};
    end
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    $display("mismatch at request %0d: %s", checked, what);
  endtask

  // APB write: setup cycle, then access cycle; the register takes the value at its end.
  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      vcwl_pkg::REG_TIMEOUT: cfg_now.timeout_ms = value[15:0];
      vcwl_pkg::REG_HOLD:    cfg_now.hold_duration_ms = value[15:0];
      vcwl_pkg::REG_LIMIT_X: cfg_now.limit_x = value[14:0];
      vcwl_pkg::REG_LIMIT_Y: cfg_now.limit_y = value[14:0];
      vcwl_pkg::REG_LIMIT_T: cfg_now.limit_turn = value[14:0];
      vcwl_pkg::REG_DB_LIN:  cfg_now.deadband_lin = value[14:0];
      vcwl_pkg::REG_DB_TURN: cfg_now.deadband_turn = value[14:0];
      default:               cfg_now.mode_bits = value[1:0];
    endcase
  endtask

  task automatic queue_item(logic [1:0] action, logic [31:0] stamp, logic signed [15:0] x,
                            logic signed [15:0] y, logic signed [15:0] t);
    action_item_t it;
    it.action = action;
    it.stamp = stamp;
    it.x = x;
    it.y = y;
    it.turn = t;
    queued_actions = {queued_actions, it};
  endtask

  // Waits until every item is sent and every request seen, then lets the pipeline settle.
  task automatic wait_drained();
    while (queued_actions.size() != 0 || sending || due_requests.size() != 0) begin
      @(posedge clk);
    end
    repeat (6) @(posedge clk);
  endtask

  // Speeds gather at the rails, the limits and the deadband edges.
  function automatic logic [15:0] pick_speed(int lim, int db);
    int v;
    case ($urandom_range(7))
      0:       v = -32768;
      1:       v = 32767;
      2:       v = lim + $urandom_range(0, 2) - 1;
      3:       v = db + $urandom_range(0, 2) - 1;
      4:       v = 0;
      default: v = $urandom_range(0, 65535);
    endcase
    if ($urandom_range(1) == 1) begin
      v = -v;
    end
    return v[15:0];
  endfunction

  // Phase one takes every register at its top, phase four at zero, the rest at random.
  function automatic logic [31:0] phase_value(int p, int hi, int typical);
    if (p == 1) begin
      return hi;
    end else if (p == 4) begin
      return 0;
    end
    case ($urandom_range(5))
      0:       return 0;
      1:       return hi;
      2:       return $urandom_range(0, hi);
      default: return $urandom_range(0, typical);
    endcase
  endfunction

  // Commands mostly followed by ticks around the timeout edge of the last command.
  task automatic queue_random_items(int count);
    int          roll;
    int          t;
    logic [31:0] stamp;
    logic [15:0] x, y, w;
    t = cfg_now.timeout_ms;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      x = pick_speed(cfg_now.limit_x, cfg_now.deadband_lin);
      y = pick_speed(cfg_now.limit_y, cfg_now.deadband_lin);
      w = pick_speed(cfg_now.limit_turn, cfg_now.deadband_turn);
      if (roll < 25) begin
        case ($urandom_range(9))
          0:       stamp = $urandom;
          1:       stamp = 32'hFFFF_FFFF - $urandom_range(0, t);
          default: stamp = cmd_stamp + $urandom_range(0, 2 * t + 2);
        endcase
        cmd_stamp = stamp;
        queue_item(vcwl_pkg::ACT_COMMAND, stamp, x, y, w);
      end else if (roll < 85) begin
        case ($urandom_range(7))
          0:       stamp = cmd_stamp + t;
          1:       stamp = cmd_stamp + t + 1;
          2:       stamp = $urandom;
          3:       stamp = cmd_stamp + t + $urandom_range(2, 1000);
          default: stamp = cmd_stamp + $urandom_range(0, t);
        endcase
        queue_item(vcwl_pkg::ACT_TICK, stamp, x, y, w);
      end else if (roll < 92) begin
        queue_item(vcwl_pkg::ACT_STOP, $urandom, x, y, w);
      end else begin
        queue_item(vcwl_pkg::ACT_START, $urandom, x, y, w);
      end
    end
  endtask

  // Driver: presents queued items, predicting each one as it is accepted.
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        watchdog_step(on_wire);
        sending = 1'b0;
      end
      if (!sending && queued_actions.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        on_wire = queued_actions.pop_front();
        cmd_ch.action <= on_wire.action;
        cmd_ch.stamp_ms <= on_wire.stamp;
        cmd_ch.cmd_x <= on_wire.x;
        cmd_ch.cmd_y <= on_wire.y;
        cmd_ch.cmd_turn <= on_wire.turn;
        sending = 1'b1;
      end
      cmd_ch.valid <= sending;
    end
  end

  // Monitor: checks each accepted request against the oldest prediction.
  always @(posedge clk) begin : request_monitor
    vcwl_pkg::result_t want;
    string             diff;
    if (rst) begin
      req_ch.ready <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        if (due_requests.size() == 0) begin
          report_mismatch($sformatf("unexpected request kind %0d x %0d", req_ch.request_kind,
                                    req_ch.out_x));
        end else begin
          want = due_requests.pop_front();
          diff = "";
          if (req_ch.request_kind !== want.request_kind) begin
            diff = {diff, $sformatf(" kind %0d/%0d", req_ch.request_kind, want.request_kind)};
          end
          if (req_ch.out_x !== want.out_x) begin
            diff = {diff, $sformatf(" x %0d/%0d", req_ch.out_x, want.out_x)};
          end
          if (req_ch.out_y !== want.out_y) begin
            diff = {diff, $sformatf(" y %0d/%0d", req_ch.out_y, want.out_y)};
          end
          if (req_ch.out_turn !== want.out_turn) begin
            diff = {diff, $sformatf(" turn %0d/%0d", req_ch.out_turn, want.out_turn)};
          end
          if (req_ch.out_duration_ms !== want.out_duration_ms) begin
            diff = {diff, $sformatf(" duration %0d/%0d", req_ch.out_duration_ms,
                                    want.out_duration_ms)};
          end
          if (req_ch.last_of_run !== want.last_of_run) begin
            diff = {diff, $sformatf(" last %0d/%0d", req_ch.last_of_run, want.last_of_run)};
          end
          if (diff != "") begin
            report_mismatch({"got/expected", diff});
          end
        end
        checked++;
      end
      req_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : stimulus
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.action = vcwl_pkg::ACT_COMMAND;
    cmd_ch.stamp_ms = '0;
    cmd_ch.cmd_x = '0;
    cmd_ch.cmd_y = '0;
    cmd_ch.cmd_turn = '0;
    req_ch.ready = 1'b0;
    send_idle_pct = 16;
    recv_idle_pct = 80;
    cfg_now = '{vcwl_pkg::RST_TIMEOUT, vcwl_pkg::RST_HOLD, vcwl_pkg::RST_LIMIT_X,
                vcwl_pkg::RST_LIMIT_Y, vcwl_pkg::RST_LIMIT_T, vcwl_pkg::RST_DB_LIN,
                vcwl_pkg::RST_DB_TURN, vcwl_pkg::RST_MODE};
    cmd_seen = 1'b0;
    stop_sent = 1'b0;
    start_sent = 1'b0;
    kept_x = '0;
    kept_y = '0;
    kept_turn = '0;
    kept_stamp = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Early stop and auto start on, everything else at reset values.
    write_reg(vcwl_pkg::REG_MODE, 32'd3);
    queue_item(vcwl_pkg::ACT_TICK, 32'd0, 0, 0, 0);
    queue_item(vcwl_pkg::ACT_TICK, 32'd1, 0, 0, 0);
    queue_item(vcwl_pkg::ACT_STOP, 32'd2, 0, 0, 0);
    // Forward rail, lateral most negative, yaw inside the deadband.
    queue_item(vcwl_pkg::ACT_COMMAND, 32'hFFFF_FF00, 16'sh7FFF, 16'sh8000, 16'sd3);
    // Ticks across the stamp wrap: live with auto start, live again, age at the timeout,
    // one past it, and a second stale tick that stays silent.
    queue_item(vcwl_pkg::ACT_TICK, 32'h0000_00F0, 0, 0, 0);
    queue_item(vcwl_pkg::ACT_TICK, 32'h0000_00F0, 0, 0, 0);
    queue_item(vcwl_pkg::ACT_TICK, 32'h0000_00F4, 0, 0, 0);
    queue_item(vcwl_pkg::ACT_TICK, 32'h0000_00F5, 0, 0, 0);
    queue_item(vcwl_pkg::ACT_TICK, 32'h0000_0200, 0, 0, 0);
    // Manual start repeated although already started.
    queue_item(vcwl_pkg::ACT_START, 32'h0000_0201, 0, 0, 0);
    queue_item(vcwl_pkg::ACT_START, 32'h0000_0202, 0, 0, 0);
    queue_item(vcwl_pkg::ACT_COMMAND, 32'hFFFF_FFFF, 16'sh8000, 16'sd4, -16'sd4);
    queue_item(vcwl_pkg::ACT_TICK, 32'hFFFF_FFFF, 0, 0, 0);
    wait_drained();

    // Zero timeout, zero forward limit, no linear deadband, full yaw deadband.
    write_reg(vcwl_pkg::REG_TIMEOUT, 32'd0);
    write_reg(vcwl_pkg::REG_HOLD, 32'h0000_FFFF);
    write_reg(vcwl_pkg::REG_LIMIT_X, 32'd0);
    write_reg(vcwl_pkg::REG_LIMIT_Y, 32'h0000_7FFF);
    write_reg(vcwl_pkg::REG_LIMIT_T, 32'h0000_7FFF);
    write_reg(vcwl_pkg::REG_DB_LIN, 32'd0);
    write_reg(vcwl_pkg::REG_DB_TURN, 32'h0000_7FFF);
    write_reg(vcwl_pkg::REG_MODE, 32'd0);
    queue_item(vcwl_pkg::ACT_COMMAND, 32'd1000, 16'sd1, 16'sh8000, 16'sd32767);
    queue_item(vcwl_pkg::ACT_TICK, 32'd1000, 0, 0, 0);
    queue_item(vcwl_pkg::ACT_TICK, 32'd1001, 0, 0, 0);
    queue_item(vcwl_pkg::ACT_STOP, 32'd1002, 0, 0, 0);
    queue_item(vcwl_pkg::ACT_COMMAND, 32'd5, 0, 0, 0);
    queue_item(vcwl_pkg::ACT_TICK, 32'd5, 0, 0, 0);
    queue_item(vcwl_pkg::ACT_COMMAND, 32'hFFFF_FFFF, -16'sd1, 16'sd1, -16'sd32767);
    queue_item(vcwl_pkg::ACT_TICK, 32'd0, 0, 0, 0);

    // Random phases, each with its own register setting and idling pattern.
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      case (p % 3)
        0: begin
          send_idle_pct = 16;
          recv_idle_pct = 80;
        end
        1: begin
          send_idle_pct = 80;
          recv_idle_pct = 16;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_reg(vcwl_pkg::REG_TIMEOUT, phase_value(p, 65535, 2000));
      write_reg(vcwl_pkg::REG_HOLD, phase_value(p, 65535, 65535));
      write_reg(vcwl_pkg::REG_LIMIT_X, phase_value(p, 32767, 4096));
      write_reg(vcwl_pkg::REG_LIMIT_Y, phase_value(p, 32767, 4096));
      write_reg(vcwl_pkg::REG_LIMIT_T, phase_value(p, 32767, 4096));
      write_reg(vcwl_pkg::REG_DB_LIN, phase_value(p, 32767, 200));
      write_reg(vcwl_pkg::REG_DB_TURN, phase_value(p, 32767, 200));
      write_reg(vcwl_pkg::REG_MODE, phase_value(p, 3, 3));
      queue_random_items(165);
    end

    while (queued_actions.size() != 0 || sending || due_requests.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (mismatches == 0 && due_requests.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : run_limit
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
